@@ rtl/mfme_pkg.sv @@
// Shared constants, payload types and command codes of the median-filtered mode estimator.
`default_nettype none

package mfme_pkg;

   // Median window and the span of recent samples that it covers.
   localparam int WINDOW_SIZE = 5;
   localparam int HALF        = WINDOW_SIZE / 2;
   localparam int SPAN        = 2 * HALF + 1;

   // Histogram geometry and counter saturation.
   localparam int MAX_PERSON_COUNT = 255;
   localparam int BINS             = MAX_PERSON_COUNT + 1;
   localparam int BIN_W            = $clog2(BINS);
   localparam int VAL_W            = BIN_W;
   localparam int MAX_SAMPLES      = 65535;
   localparam int CNT_W            = $clog2(MAX_SAMPLES + 1);

   // Window positions, sort keys and sorter counters.
   localparam int POS_W  = $clog2(SPAN + 1);
   localparam int IDX_W  = $clog2(SPAN);
   localparam int PASS_W = $clog2(SPAN - 1);
   localparam int KEY_W  = VAL_W + 1;

   typedef logic [SPAN-1:0][KEY_W-1:0] key_vec_type;
   typedef logic [SPAN-1:0][VAL_W-1:0] sample_vec_type;

   // Input beat.
   typedef struct packed {
      logic [7:0] person_count;
      logic       last;
   } req_type;

   // Result beat.
   typedef struct packed {
      logic [7:0]  class_size;
      logic [15:0] mode_frequency;
      logic [15:0] sample_total;
   } rsp_type;

   // Operations on the histogram memory.
   typedef enum logic [2:0] {
      HIST_NOP,
      HIST_CLEAR,
      HIST_READ,
      HIST_INC,
      HIST_SCAN
   } hist_op_type;

   typedef struct packed {
      hist_op_type      op;
      logic [BIN_W-1:0] addr;
   } hist_cmd_type;

   // Running best bin of a histogram scan.
   typedef struct packed {
      logic [VAL_W-1:0] value;
      logic [CNT_W-1:0] count;
   } mode_type;

endpackage

`default_nettype wire

@@ rtl/mfme_sort.sv @@
// Sorter that orders the window keys with one shared compare-exchange unit.
`default_nettype none

module mfme_sort (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 load,
   input  wire mfme_pkg::key_vec_type keys,
   output mfme_pkg::key_vec_type     sorted,
   output logic                      done
);
   import mfme_pkg::*;

   key_vec_type       q_ff, q_in;
   logic              run_ff, run_in;
   logic              done_ff, done_in;
   logic [IDX_W-1:0]  step_ff, step_in;
   logic [PASS_W-1:0] pass_ff, pass_in;
   logic [KEY_W-1:0]  hi_key, lo_key;
   logic              swap;

   // The shared unit always compares the two keys at the head of the queue.
   always_comb begin
      swap   = q_ff[0] > q_ff[1];
      hi_key = swap ? q_ff[0] : q_ff[1];
      lo_key = swap ? q_ff[1] : q_ff[0];
   end

   // Each pass keeps the larger key at the head and sends the smaller one to the
   // tail; the last step of a pass rotates the pass maximum to the tail.
   always_comb begin
      q_in    = q_ff;
      run_in  = run_ff;
      done_in = 1'b0;
      step_in = step_ff;
      pass_in = pass_ff;
      if (load) begin
         q_in    = keys;
         run_in  = 1'b1;
         step_in = '0;
         pass_in = '0;
      end else if (run_ff) begin
         for (int i = 1; i < SPAN - 1; i++) begin
            q_in[i] = q_ff[i+1];
         end
         if (step_ff == IDX_W'(SPAN - 1)) begin
            q_in[0]      = q_ff[1];
            q_in[SPAN-1] = q_ff[0];
            step_in      = '0;
            if (pass_ff == PASS_W'(SPAN - 2)) begin
               run_in  = 1'b0;
               done_in = 1'b1;
            end else begin
               pass_in = pass_ff + 1'b1;
            end
         end else begin
            q_in[0]      = hi_key;
            q_in[SPAN-1] = lo_key;
            step_in      = step_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      q_ff <= q_in;
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
         pass_ff <= '0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
         step_ff <= step_in;
         pass_ff <= pass_in;
      end
   end

   assign sorted = q_ff;
   assign done   = done_ff;

endmodule

`default_nettype wire

@@ rtl/mfme_hist.sv @@
// Histogram memory with saturating increment and a read-and-clear mode scan.
`default_nettype none

module mfme_hist (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire mfme_pkg::hist_cmd_type cmd,
   output mfme_pkg::mode_type          mode
);
   import mfme_pkg::*;

   logic [CNT_W-1:0] bins_mem [BINS];
   logic [CNT_W-1:0] rdata_ff;
   logic [CNT_W-1:0] wr_data;
   logic             wr_en, rd_en;
   logic             scan_vld_ff, scan_vld_in;
   logic [BIN_W-1:0] scan_addr_ff;
   mode_type         best_ff, best_in;

   // Decode the command into memory port controls.
   always_comb begin
      wr_en   = 1'b0;
      rd_en   = 1'b0;
      wr_data = '0;
      unique case (cmd.op)
         HIST_NOP: begin
         end
         HIST_CLEAR: begin
            wr_en = 1'b1;
         end
         HIST_READ: begin
            rd_en = 1'b1;
         end
         HIST_INC: begin
            wr_en   = 1'b1;
            wr_data = (rdata_ff == CNT_W'(MAX_SAMPLES)) ? rdata_ff : rdata_ff + 1'b1;
         end
         HIST_SCAN: begin
            wr_en = 1'b1;
            rd_en = 1'b1;
         end
         default: begin
         end
      endcase
   end

   // Single-port memory, read first, with registered read data.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         bins_mem[cmd.addr] <= wr_data;
      end
      if (rd_en) begin
         rdata_ff <= bins_mem[cmd.addr];
      end
   end

   // Track the most frequent bin; later bins win ties.
   always_comb begin
      scan_vld_in = (cmd.op == HIST_SCAN);
      best_in     = best_ff;
      priority if (cmd.op == HIST_SCAN && cmd.addr == '0) begin
         best_in = '0;
      end else if (scan_vld_ff && rdata_ff != '0 && rdata_ff >= best_ff.count) begin
         best_in.value = scan_addr_ff;
         best_in.count = rdata_ff;
      end
   end

   always_ff @(posedge clock) begin
      scan_addr_ff <= cmd.addr;
      best_ff      <= best_in;
      if (reset) begin
         scan_vld_ff <= 1'b0;
      end else begin
         scan_vld_ff <= scan_vld_in;
      end
   end

   assign mode = best_ff;

endmodule

`default_nettype wire

@@ rtl/median_filtered_mode_estimator.sv @@
// Top level: sample window, session sequencer and result register of the estimator.
`default_nettype none

// Estimates the class size of a session of person-count samples.
// A beat on the request side is taken when start is high and busy is low.
// A nonzero person_count enters a five-sample window; each position is
// median filtered (window truncated at the session ends) into a 256-bin
// histogram. A beat with last set also filters the trailing positions,
// then scans every bin for the mode and clears it in the same sweep.
// A sample that completes a window keeps busy high while the sort is set
// up, the single compare-exchange unit runs its 20 steps, the sort finish
// is seen and the median bin read, the bin is written and control returns.
// A zero sample, or one with fewer than three in the window, is not filtered.
// A last beat runs up to three such filters, then scans every bin through
// the histogram port; its result follows through the drain and emit states.
// The result is flagged by rsp_valid for exactly one cycle and held on rsp_data;
// the receiver cannot stall, and a new beat may be taken in that cycle.
// After reset the block sweeps the histogram to zero, one bin a cycle,
// over all 256 bins with busy high before the first beat is taken.
module median_filtered_mode_estimator (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              start,
   output logic                   busy,
   input  wire mfme_pkg::req_type req_data,
   output logic                   rsp_valid,
   output mfme_pkg::rsp_type      rsp_data
);
   import mfme_pkg::*;

   typedef enum logic [7:0] {
      ST_CLEAR = 8'b0000_0001,
      ST_IDLE  = 8'b0000_0010,
      ST_PREP  = 8'b0000_0100,
      ST_SORT  = 8'b0000_1000,
      ST_INC   = 8'b0001_0000,
      ST_SCAN  = 8'b0010_0000,
      ST_DRAIN = 8'b0100_0000,
      ST_EMIT  = 8'b1000_0000
   } state_type;

   state_type        state_ff, state_in;
   sample_vec_type   recent_ff, recent_in;
   logic [CNT_W-1:0] total_ff, total_in;
   logic             stream_ff, stream_in;
   logic             last_ff, last_in;
   logic             tail_left_ff, tail_left_in;
   logic [POS_W-1:0] tail_ff, tail_in;
   logic [BIN_W-1:0] addr_ff, addr_in;
   logic [IDX_W-1:0] med_idx_ff, med_idx_in;
   logic             rsp_valid_ff, rsp_valid_in;
   rsp_type          rsp_data_ff, rsp_data_in;

   logic [POS_W-1:0] nvalid;
   logic [POS_W-1:0] job_age, lo, hi, hi_raw, win_n;
   logic [VAL_W-1:0] sample;
   logic             sort_load, sort_done;
   key_vec_type      keys, sorted;
   hist_cmd_type     hist_cmd;
   mode_type         mode;

   mfme_sort u_sort (
      .clock  (clock),
      .reset  (reset),
      .load   (sort_load),
      .keys   (keys),
      .sorted (sorted),
      .done   (sort_done)
   );

   mfme_hist u_hist (
      .clock   (clock),
      .reset   (reset),
      .cmd     (hist_cmd),
      .mode    (mode)
   );

   // Samples present in the window, and the clamped incoming sample.
   always_comb begin
      nvalid = (total_ff < CNT_W'(SPAN)) ? POS_W'(total_ff) : POS_W'(SPAN);
      sample = (VAL_W'(req_data.person_count) > VAL_W'(MAX_PERSON_COUNT)) ?
               VAL_W'(MAX_PERSON_COUNT) : VAL_W'(req_data.person_count);
   end

   // Window bounds of the position being filtered; entries outside sort last.
   always_comb begin
      lo     = (job_age >= POS_W'(HALF)) ? job_age - POS_W'(HALF) : '0;
      hi_raw = job_age + POS_W'(HALF);
      hi     = (hi_raw > nvalid - 1'b1) ? nvalid - 1'b1 : hi_raw;
      win_n  = hi - lo + 1'b1;
      for (int i = 0; i < SPAN; i++) begin
         keys[i] = {~((POS_W'(i) >= lo) && (POS_W'(i) <= hi)), recent_ff[i]};
      end
   end

   // Session sequencer.
   always_comb begin
      state_in     = state_ff;
      recent_in    = recent_ff;
      total_in     = total_ff;
      stream_in    = stream_ff;
      last_in      = last_ff;
      tail_left_in = tail_left_ff;
      tail_in      = tail_ff;
      addr_in      = addr_ff;
      med_idx_in   = med_idx_ff;
      rsp_valid_in = 1'b0;
      rsp_data_in  = rsp_data_ff;
      job_age      = POS_W'(HALF);
      sort_load    = 1'b0;
      hist_cmd.op   = HIST_NOP;
      hist_cmd.addr = addr_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            hist_cmd.op = HIST_CLEAR;
            addr_in     = addr_ff + 1'b1;
            if (addr_ff == BIN_W'(BINS - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (start) begin
               if (sample != '0) begin
                  recent_in[0] = sample;
                  for (int i = 1; i < SPAN; i++) begin
                     recent_in[i] = recent_ff[i-1];
                  end
                  if (total_ff != CNT_W'(MAX_SAMPLES)) begin
                     total_in = total_ff + 1'b1;
                  end
               end
               stream_in    = (sample != '0);
               last_in      = req_data.last;
               tail_left_in = req_data.last;
               tail_in      = POS_W'(HALF - 1);
               state_in     = ST_PREP;
            end
         end
         ST_PREP: begin
            // Pick the next position to filter, or move on.
            priority if (stream_ff) begin
               stream_in = 1'b0;
               if (nvalid > POS_W'(HALF)) begin
                  job_age   = POS_W'(HALF);
                  sort_load = 1'b1;
                  state_in  = ST_SORT;
               end
            end else if (tail_left_ff) begin
               tail_left_in = (tail_ff != '0);
               tail_in      = tail_ff - 1'b1;
               if (tail_ff < nvalid) begin
                  job_age   = tail_ff;
                  sort_load = 1'b1;
                  state_in  = ST_SORT;
               end
            end else if (last_ff) begin
               addr_in  = '0;
               state_in = ST_SCAN;
            end else begin
               state_in = ST_IDLE;
            end
            if (sort_load) begin
               med_idx_in = IDX_W'(win_n >> 1);
            end
         end
         ST_SORT: begin
            if (sort_done) begin
               addr_in       = sorted[med_idx_ff][VAL_W-1:0];
               hist_cmd.op   = HIST_READ;
               hist_cmd.addr = sorted[med_idx_ff][VAL_W-1:0];
               state_in      = ST_INC;
            end
         end
         ST_INC: begin
            hist_cmd.op = HIST_INC;
            state_in    = ST_PREP;
         end
         ST_SCAN: begin
            hist_cmd.op = HIST_SCAN;
            addr_in     = addr_ff + 1'b1;
            if (addr_ff == BIN_W'(BINS - 1)) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            rsp_valid_in               = 1'b1;
            rsp_data_in.class_size     = 8'(mode.value);
            rsp_data_in.mode_frequency = 16'(mode.count);
            rsp_data_in.sample_total   = 16'(total_ff);
            total_in                   = '0;
            last_in                    = 1'b0;
            state_in                   = ST_IDLE;
         end
         default: begin
            state_in = ST_CLEAR;
            addr_in  = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      med_idx_ff  <= med_idx_in;
      rsp_data_ff <= rsp_data_in;
      if (reset) begin
         state_ff     <= ST_CLEAR;
         recent_ff    <= '0;
         total_ff     <= '0;
         stream_ff    <= 1'b0;
         last_ff      <= 1'b0;
         tail_left_ff <= 1'b0;
         tail_ff      <= '0;
         addr_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         recent_ff    <= recent_in;
         total_ff     <= total_in;
         stream_ff    <= stream_in;
         last_ff      <= last_in;
         tail_left_ff <= tail_left_in;
         tail_ff      <= tail_in;
         addr_ff      <= addr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign busy      = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

`default_nettype wire
